/* rtl/core/llf_pkg.sv */
// Package for the link lifecycle sequencer.
// Holds the word types, phase and event codes, action bits and the generation step.
// No dependencies.
package llf_pkg;

    localparam int GEN_WIDTH = 32;
    localparam int OPID_WIDTH = 32;
    localparam int HANDLE_WIDTH = 16;
    localparam int ACT_WIDTH = 9;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;

    localparam logic [PADDR_WIDTH-1:0] ADDR_INVALID_HANDLE = 3'd0;
    localparam logic [HANDLE_WIDTH-1:0] INVALID_HANDLE_RESET = 16'hFFFF;

    // Event codes.
    localparam logic [3:0] OP_START       = 4'd0;
    localparam logic [3:0] OP_STOP        = 4'd1;
    localparam logic [3:0] OP_BACKOFF_EXP = 4'd2;
    localparam logic [3:0] OP_SCAN_START  = 4'd3;
    localparam logic [3:0] OP_ADVERT      = 4'd4;
    localparam logic [3:0] OP_CONN_ISSUED = 4'd5;
    localparam logic [3:0] OP_CONNECTED   = 4'd6;
    localparam logic [3:0] OP_DISCOVERED  = 4'd7;
    localparam logic [3:0] OP_SUBSCRIBED  = 4'd8;
    localparam logic [3:0] OP_INITIALIZED = 4'd9;
    localparam logic [3:0] OP_DISCONNECT  = 4'd10;
    localparam logic [3:0] OP_FAILED      = 4'd11;
    localparam logic [3:0] OP_DEADLINE    = 4'd12;

    // Reported phase codes.
    localparam logic [3:0] CODE_IDLE     = 4'd0;
    localparam logic [3:0] CODE_SCAN     = 4'd1;
    localparam logic [3:0] CODE_CAND     = 4'd2;
    localparam logic [3:0] CODE_CONN     = 4'd3;
    localparam logic [3:0] CODE_DISC     = 4'd4;
    localparam logic [3:0] CODE_SUBS     = 4'd5;
    localparam logic [3:0] CODE_INIT     = 4'd6;
    localparam logic [3:0] CODE_READY    = 4'd7;
    localparam logic [3:0] CODE_BACKOFF  = 4'd8;
    localparam logic [3:0] CODE_STOPPED  = 4'd9;

    // Action bits.
    localparam logic [ACT_WIDTH-1:0] ACT_CLEANUP   = 9'h001;
    localparam logic [ACT_WIDTH-1:0] ACT_BACKOFF   = 9'h002;
    localparam logic [ACT_WIDTH-1:0] ACT_STARTSCAN = 9'h004;
    localparam logic [ACT_WIDTH-1:0] ACT_STOPSCAN  = 9'h008;
    localparam logic [ACT_WIDTH-1:0] ACT_CONNECT   = 9'h010;
    localparam logic [ACT_WIDTH-1:0] ACT_DISCOVER  = 9'h020;
    localparam logic [ACT_WIDTH-1:0] ACT_SUBSCRIBE = 9'h040;
    localparam logic [ACT_WIDTH-1:0] ACT_INIT      = 9'h080;
    localparam logic [ACT_WIDTH-1:0] ACT_READY     = 9'h100;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_SCAN    = 10'b00_0000_0010,
        PH_CAND    = 10'b00_0000_0100,
        PH_CONN    = 10'b00_0000_1000,
        PH_DISC    = 10'b00_0001_0000,
        PH_SUBS    = 10'b00_0010_0000,
        PH_INIT    = 10'b00_0100_0000,
        PH_READY   = 10'b00_1000_0000,
        PH_BACKOFF = 10'b01_0000_0000,
        PH_STOPPED = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [3:0]              op;
        logic [GEN_WIDTH-1:0]    event_generation;
        logic [OPID_WIDTH-1:0]   event_operation_id;
        logic [HANDLE_WIDTH-1:0] event_handle;
    } t_in_word;

    typedef struct packed {
        logic                    accepted_flag;
        logic [ACT_WIDTH-1:0]    action_mask;
        logic [3:0]              next_phase;
        logic [GEN_WIDTH-1:0]    next_generation;
        logic [OPID_WIDTH-1:0]   next_operation_id;
        logic [HANDLE_WIDTH-1:0] next_handle;
    } t_out_word;

    // Generation step: wraps, and a wrap to zero is replaced by one.
    function automatic logic [GEN_WIDTH-1:0] gen_advance(input logic [GEN_WIDTH-1:0] g);
        logic [GEN_WIDTH-1:0] n;
        n = g + GEN_WIDTH'(1);
        return (n == '0) ? GEN_WIDTH'(1) : n;
    endfunction

    function automatic logic [3:0] phase_code(input t_phase ph);
        logic [3:0] c;
        unique case (ph)
            PH_IDLE:    c = CODE_IDLE;
            PH_SCAN:    c = CODE_SCAN;
            PH_CAND:    c = CODE_CAND;
            PH_CONN:    c = CODE_CONN;
            PH_DISC:    c = CODE_DISC;
            PH_SUBS:    c = CODE_SUBS;
            PH_INIT:    c = CODE_INIT;
            PH_READY:   c = CODE_READY;
            PH_BACKOFF: c = CODE_BACKOFF;
            PH_STOPPED: c = CODE_STOPPED;
            default:    c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/link_lifecycle_fsm.sv */
// Link lifecycle sequencer: top level with input register, event decode and result register.
// Depends on llf_pkg.
//
// Usage:
// Events enter on i_valid / o_stall with payload i_word; one result word per event
// leaves on o_valid / i_stall with payload o_word. A word is taken at a rising edge
// where valid is high and stall is low.
// o_valid rises when the event leaves the input register: the decode against the stored
// phase, generation, operation id and handle writes the result register and the stored
// state together. The event waits in the input register while a stalled result is held.
// Throughput is one event per cycle while the receiver does not stall, set by the
// combinational decode between the input register and the result register.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more event; o_stall rises only when both are full.
// The invalid_handle register sits at byte address 0 of the APB-style port; pready is always
// high. Write invalid_handle only while no event is in flight; the block does not enforce it.
// Reset (synchronous, active low) empties both stages and returns the state to idle,
// generation zero, operation id zero and the handle to 16'hFFFF.
module link_lifecycle_fsm
    import llf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in_word               i_word,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_out_word              o_word,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready
);

    logic                    r_in_valid;
    t_in_word                r_in_word;
    logic                    r_out_valid;
    t_out_word               r_out_word;
    logic [HANDLE_WIDTH-1:0] r_invalid_handle;

    t_phase                  r_phase;
    logic [GEN_WIDTH-1:0]    r_gen;
    logic [OPID_WIDTH-1:0]   r_op_id;
    logic [HANDLE_WIDTH-1:0] r_handle;

    t_phase                  n_phase;
    logic [GEN_WIDTH-1:0]    n_gen;
    logic [OPID_WIDTH-1:0]   n_op_id;
    logic [HANDLE_WIDTH-1:0] n_handle;
    logic                    acc;
    logic [ACT_WIDTH-1:0]    act;

    logic out_free;
    logic fire;
    logic match;
    logic active_phase;
    logic cfg_wr;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_word   = r_out_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_INVALID_HANDLE) ?
                    {{(PDATA_WIDTH-HANDLE_WIDTH){1'b0}}, r_invalid_handle} : '0;

    assign match = (r_in_word.event_generation == r_gen) &&
                   (r_in_word.event_operation_id != '0) &&
                   (r_in_word.event_operation_id == r_op_id);
    assign active_phase = (r_phase != PH_IDLE) && (r_phase != PH_STOPPED) &&
                          (r_phase != PH_BACKOFF);

    always_comb begin
        n_phase  = r_phase;
        n_gen    = r_gen;
        n_op_id  = r_op_id;
        n_handle = r_handle;
        acc      = 1'b0;
        act      = '0;
        priority if (r_in_word.op == OP_STOP) begin
            acc      = 1'b1;
            act      = ACT_CLEANUP;
            n_phase  = PH_STOPPED;
            n_gen    = gen_advance(r_gen);
            n_op_id  = '0;
            n_handle = r_invalid_handle;
        end else if (r_in_word.op == OP_START) begin
            if (r_phase == PH_IDLE || r_phase == PH_STOPPED) begin
                acc      = 1'b1;
                act      = ACT_STARTSCAN;
                n_phase  = PH_SCAN;
                n_gen    = gen_advance(r_gen);
                n_op_id  = r_in_word.event_operation_id;
                n_handle = r_invalid_handle;
            end
        end else if (r_phase == PH_BACKOFF && r_in_word.op == OP_BACKOFF_EXP &&
                     r_in_word.event_generation == r_gen &&
                     r_in_word.event_operation_id != '0) begin
            // Backoff expiry keeps the link handle as it is.
            acc     = 1'b1;
            act     = ACT_STARTSCAN;
            n_phase = PH_SCAN;
            n_gen   = gen_advance(r_gen);
            n_op_id = r_in_word.event_operation_id;
        end else if (match) begin
            priority if (r_phase == PH_SCAN && r_in_word.op == OP_SCAN_START) begin
                acc = 1'b1;
            end else if (r_phase == PH_SCAN && r_in_word.op == OP_ADVERT) begin
                acc     = 1'b1;
                act     = ACT_STOPSCAN | ACT_CONNECT;
                n_phase = PH_CAND;
            end else if (r_phase == PH_CAND && r_in_word.op == OP_CONN_ISSUED) begin
                acc     = 1'b1;
                n_phase = PH_CONN;
            end else if (r_phase == PH_CONN && r_in_word.op == OP_CONNECTED) begin
                acc      = 1'b1;
                act      = ACT_DISCOVER;
                n_phase  = PH_DISC;
                n_handle = r_in_word.event_handle;
            end else if (r_phase == PH_DISC && r_in_word.op == OP_DISCOVERED) begin
                acc     = 1'b1;
                act     = ACT_SUBSCRIBE;
                n_phase = PH_SUBS;
            end else if (r_phase == PH_SUBS && r_in_word.op == OP_SUBSCRIBED) begin
                acc     = 1'b1;
                act     = ACT_INIT;
                n_phase = PH_INIT;
            end else if (r_phase == PH_INIT && r_in_word.op == OP_INITIALIZED) begin
                acc     = 1'b1;
                act     = ACT_READY;
                n_phase = PH_READY;
            end else if ((r_in_word.op == OP_DISCONNECT || r_in_word.op == OP_FAILED ||
                          r_in_word.op == OP_DEADLINE) && active_phase) begin
                acc      = 1'b1;
                act      = ACT_CLEANUP | ACT_BACKOFF;
                n_phase  = PH_BACKOFF;
                n_gen    = gen_advance(r_gen);
                n_op_id  = '0;
                n_handle = r_invalid_handle;
            end else begin
                // The event does not fit the phase; the defaults reject it.
                acc = 1'b0;
            end
        end else begin
            // A mismatched generation or operation id rejects the event.
            acc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_invalid_handle <= INVALID_HANDLE_RESET;
            r_phase          <= PH_IDLE;
            r_gen            <= '0;
            r_op_id          <= '0;
            r_handle         <= INVALID_HANDLE_RESET;
        end else begin
            if (cfg_wr && paddr == ADDR_INVALID_HANDLE) begin
                r_invalid_handle <= pwdata[HANDLE_WIDTH-1:0];
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase  <= n_phase;
                r_gen    <= n_gen;
                r_op_id  <= n_op_id;
                r_handle <= n_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word <= i_word;
        end
        if (fire) begin
            r_out_word.accepted_flag     <= acc;
            r_out_word.action_mask       <= act;
            r_out_word.next_phase        <= phase_code(n_phase);
            r_out_word.next_generation   <= n_gen;
            r_out_word.next_operation_id <= n_op_id;
            r_out_word.next_handle       <= n_handle;
        end
    end

    // A rejected event never reports an action.
    a_reject_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.accepted_flag) |-> (o_word.action_mask == '0))
        else $error("rejected event carries actions");

    // A cleanup always clears the operation id and leaves a nonzero generation,
    // since the generation step never lands on zero.
    a_cleanup_clears_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_word.action_mask & ACT_CLEANUP) != '0) |->
        (o_word.next_operation_id == '0 && o_word.next_generation != '0))
        else $error("cleanup left an operation id or a zero generation");

    // The phase register is always exactly one state.
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    // The state only moves when an event leaves the input register.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_phase) && $stable(r_gen) && $stable(r_op_id))
        else $error("state changed without an event");

    // A result that waits on the receiver keeps its word.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_word)))
        else $error("waiting result changed");

endmodule

/* tb/sv/link_lifecycle_checker.sv */
// Scoreboard for the link lifecycle sequencer: predicts every result word and compares.
// Watches the event, result and register-write channels of link_lifecycle_fsm.
// Depends on llf_pkg.
`timescale 1ns / 1ps

module link_lifecycle_checker
    import llf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_word               i_in_word,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_word              i_out_word,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [PADDR_WIDTH-1:0] i_paddr,
    input  logic [PDATA_WIDTH-1:0] i_pwdata,
    output t_out_word              o_lifecycle_now,
    output int                     o_pending,
    output int                     o_fail_count,
    output int                     o_checked,
    output int                     o_accepted
);

    // The lifecycle values live in the next_* fields of a result word.
    t_out_word               lifecycle;
    t_out_word               step_now;
    t_out_word               oldest;
    logic [HANDLE_WIDTH-1:0] no_link_handle;
    t_out_word               awaited_results[$];
    int                      fail_count     = 0;
    int                      checked_count  = 0;
    int                      accepted_count = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;
    assign o_accepted   = accepted_count;

    function automatic t_out_word lifecycle_reset();
        t_out_word r;
        r             = '0;
        r.next_phase  = CODE_IDLE;
        r.next_handle = INVALID_HANDLE_RESET;
        return r;
    endfunction

    function automatic logic [GEN_WIDTH-1:0] bump_gen(input logic [GEN_WIDTH-1:0] g);
        logic [GEN_WIDTH-1:0] n;
        n = g + 1'b1;
        if (n == '0) n = GEN_WIDTH'(1);
        return n;
    endfunction

    function automatic t_out_word lifecycle_step(input t_out_word cur, input t_in_word ev,
                                                 input logic [HANDLE_WIDTH-1:0] no_link);
        t_out_word r;
        logic      gen_ok;
        logic      opid_ok;
        logic      active;
        r               = cur;
        r.accepted_flag = 1'b0;
        r.action_mask   = '0;
        gen_ok  = (ev.event_generation == cur.next_generation);
        opid_ok = (ev.event_operation_id != '0) &&
                  (ev.event_operation_id == cur.next_operation_id);
        active  = (cur.next_phase != CODE_IDLE) && (cur.next_phase != CODE_STOPPED) &&
                  (cur.next_phase != CODE_BACKOFF);
        if (ev.op == OP_STOP) begin
            r.accepted_flag     = 1'b1;
            r.action_mask       = ACT_CLEANUP;
            r.next_phase        = CODE_STOPPED;
            r.next_generation   = bump_gen(cur.next_generation);
            r.next_operation_id = '0;
            r.next_handle       = no_link;
        end else if (ev.op == OP_START) begin
            if (cur.next_phase == CODE_IDLE || cur.next_phase == CODE_STOPPED) begin
                r.accepted_flag     = 1'b1;
                r.action_mask       = ACT_STARTSCAN;
                r.next_phase        = CODE_SCAN;
                r.next_generation   = bump_gen(cur.next_generation);
                r.next_operation_id = ev.event_operation_id;
                r.next_handle       = no_link;
            end
        end else if (cur.next_phase == CODE_BACKOFF && ev.op == OP_BACKOFF_EXP && gen_ok &&
                     ev.event_operation_id != '0) begin
            // Leaving backoff keeps whatever handle is stored.
            r.accepted_flag     = 1'b1;
            r.action_mask       = ACT_STARTSCAN;
            r.next_phase        = CODE_SCAN;
            r.next_generation   = bump_gen(cur.next_generation);
            r.next_operation_id = ev.event_operation_id;
        end else if (gen_ok && opid_ok) begin
            if (cur.next_phase == CODE_SCAN && ev.op == OP_SCAN_START) begin
                r.accepted_flag = 1'b1;
            end else if (cur.next_phase == CODE_SCAN && ev.op == OP_ADVERT) begin
                r.accepted_flag = 1'b1;
                r.action_mask   = ACT_STOPSCAN | ACT_CONNECT;
                r.next_phase    = CODE_CAND;
            end else if (cur.next_phase == CODE_CAND && ev.op == OP_CONN_ISSUED) begin
                r.accepted_flag = 1'b1;
                r.next_phase    = CODE_CONN;
            end else if (cur.next_phase == CODE_CONN && ev.op == OP_CONNECTED) begin
                r.accepted_flag = 1'b1;
                r.action_mask   = ACT_DISCOVER;
                r.next_phase    = CODE_DISC;
                r.next_handle   = ev.event_handle;
            end else if (cur.next_phase == CODE_DISC && ev.op == OP_DISCOVERED) begin
                r.accepted_flag = 1'b1;
                r.action_mask   = ACT_SUBSCRIBE;
                r.next_phase    = CODE_SUBS;
            end else if (cur.next_phase == CODE_SUBS && ev.op == OP_SUBSCRIBED) begin
                r.accepted_flag = 1'b1;
                r.action_mask   = ACT_INIT;
                r.next_phase    = CODE_INIT;
            end else if (cur.next_phase == CODE_INIT && ev.op == OP_INITIALIZED) begin
                r.accepted_flag = 1'b1;
                r.action_mask   = ACT_READY;
                r.next_phase    = CODE_READY;
            end else if ((ev.op == OP_DISCONNECT || ev.op == OP_FAILED ||
                          ev.op == OP_DEADLINE) && active) begin
                r.accepted_flag     = 1'b1;
                r.action_mask       = ACT_CLEANUP | ACT_BACKOFF;
                r.next_phase        = CODE_BACKOFF;
                r.next_generation   = bump_gen(cur.next_generation);
                r.next_operation_id = '0;
                r.next_handle       = no_link;
            end
        end
        return r;
    endfunction

    task automatic flag_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always_comb step_now = lifecycle_step(lifecycle, i_in_word, no_link_handle);

    // The stimulus side reads this to build events that match the live generation.
    assign o_lifecycle_now = (i_in_valid && !i_in_stall) ? step_now : lifecycle;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lifecycle      <= lifecycle_reset();
            no_link_handle <= INVALID_HANDLE_RESET;
            awaited_results.delete();
            o_pending      <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    flag_error("unexpected result word", i_out_word.next_generation, '0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_out_word.accepted_flag !== oldest.accepted_flag)
                        flag_error("accepted_flag", i_out_word.accepted_flag,
                                   oldest.accepted_flag);
                    if (i_out_word.action_mask !== oldest.action_mask)
                        flag_error("action_mask", i_out_word.action_mask, oldest.action_mask);
                    if (i_out_word.next_phase !== oldest.next_phase)
                        flag_error("next_phase", i_out_word.next_phase, oldest.next_phase);
                    if (i_out_word.next_generation !== oldest.next_generation)
                        flag_error("next_generation", i_out_word.next_generation,
                                   oldest.next_generation);
                    if (i_out_word.next_operation_id !== oldest.next_operation_id)
                        flag_error("next_operation_id", i_out_word.next_operation_id,
                                   oldest.next_operation_id);
                    if (i_out_word.next_handle !== oldest.next_handle)
                        flag_error("next_handle", i_out_word.next_handle, oldest.next_handle);
                    checked_count++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(step_now);
                lifecycle <= step_now;
                if (step_now.accepted_flag) accepted_count++;
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == ADDR_INVALID_HANDLE) begin
                no_link_handle <= i_pwdata[HANDLE_WIDTH-1:0];
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the link lifecycle sequencer testbench: clock, reset, events, stalls and verdict.
// Instantiates link_lifecycle_fsm and link_lifecycle_checker; depends on llf_pkg.
`timescale 1ns / 1ps

module testbench;
    import llf_pkg::*;

    localparam int         EVENTS_PER_SETTING = 290;
    localparam int         CYCLE_LIMIT        = 300000;
    localparam logic [3:0] OP_FIRST_UNKNOWN   = 4'd13;
    localparam logic [3:0] OP_LAST_UNKNOWN    = 4'd15;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    t_in_word               i_word  = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    t_out_word              o_word;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr   = '0;
    logic [PDATA_WIDTH-1:0] pwdata  = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    t_out_word lifecycle_now;
    int        pending;
    int        mismatches;
    int        results_checked;
    int        events_accepted;
    int        events_sent   = 0;
    int        handle_writes = 0;
    int        cycle_count   = 0;
    int        stall_mode    = 0;
    int        mode_left     = 0;

    wire [GEN_WIDTH-1:0]  cur_gen  = lifecycle_now.next_generation;
    wire [OPID_WIDTH-1:0] cur_opid = lifecycle_now.next_operation_id;

    link_lifecycle_fsm u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    link_lifecycle_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_word       (i_word),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_word      (o_word),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_lifecycle_now (lifecycle_now),
        .o_pending       (pending),
        .o_fail_count    (mismatches),
        .o_checked       (results_checked),
        .o_accepted      (events_accepted)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("** link_lifecycle_fsm: FAILED **");
            $finish;
        end
    end

    // The receiver switches between free flow, light stalls, heavy stalls and alternation.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 99) < 30);
            2: i_stall <= ($urandom_range(0, 99) < 80);
            default: i_stall <= ~i_stall;
        endcase
    end

    function automatic t_in_word event_word(input logic [3:0] op,
                                            input logic [GEN_WIDTH-1:0] gen,
                                            input logic [OPID_WIDTH-1:0] opid,
                                            input logic [HANDLE_WIDTH-1:0] handle);
        t_in_word w;
        w.op                 = op;
        w.event_generation   = gen;
        w.event_operation_id = opid;
        w.event_handle       = handle;
        return w;
    endfunction

    // Returns at the edge that takes the word, so the caller may present the next one there.
    task automatic send_word(input t_in_word w);
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        events_sent++;
    endtask

    task automatic write_invalid_handle(input logic [HANDLE_WIDTH-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_INVALID_HANDLE;
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        handle_writes++;
    endtask

    initial begin
        t_in_word                w;
        t_out_word               cur;
        logic [HANDLE_WIDTH-1:0] handle_settings[5];
        int                      burst_left;
        int                      gap;
        int                      roll;
        logic                    active;

        burst_left = 0;
        handle_settings[0] = 16'h0000;
        handle_settings[1] = 16'hFFFF;
        handle_settings[2] = 16'($urandom);
        handle_settings[3] = 16'($urandom);
        handle_settings[4] = 16'h0001;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass under the reset value of the invalid handle.
        send_word(event_word(OP_BACKOFF_EXP, '0, '0, '0));
        send_word(event_word(OP_FIRST_UNKNOWN, '0, '0, '0));
        send_word(event_word(OP_LAST_UNKNOWN, '1, '1, '1));
        // A start with no operation id locks out everything but stop.
        send_word(event_word(OP_START, cur_gen, '0, 16'hFFFF));
        send_word(event_word(OP_SCAN_START, cur_gen, '0, '0));
        send_word(event_word(OP_STOP, '1, '1, '1));
        send_word(event_word(OP_START, '1, '1, '0));
        send_word(event_word(OP_SCAN_START, cur_gen, cur_opid, '0));
        send_word(event_word(OP_ADVERT, cur_gen, cur_opid, '0));
        send_word(event_word(OP_CONN_ISSUED, cur_gen, cur_opid, '0));
        send_word(event_word(OP_CONNECTED, cur_gen, cur_opid, 16'hFFFF));
        send_word(event_word(OP_DISCOVERED, cur_gen, cur_opid, '0));
        send_word(event_word(OP_SUBSCRIBED, cur_gen, cur_opid, '0));
        send_word(event_word(OP_INITIALIZED, cur_gen, cur_opid, '0));
        send_word(event_word(OP_START, cur_gen, 32'h1, '0));
        send_word(event_word(OP_DISCONNECT, cur_gen, cur_opid, '0));
        send_word(event_word(OP_BACKOFF_EXP, cur_gen + 1'b1, 32'h1, '0));
        send_word(event_word(OP_BACKOFF_EXP, cur_gen, '0, '0));
        send_word(event_word(OP_BACKOFF_EXP, cur_gen, 32'h1, '0));
        send_word(event_word(OP_ADVERT, cur_gen, 32'h2, '0));
        send_word(event_word(OP_ADVERT, cur_gen, cur_opid, '0));
        send_word(event_word(OP_FAILED, cur_gen, cur_opid, '0));
        send_word(event_word(OP_BACKOFF_EXP, cur_gen, 32'h8000_0000, '0));
        send_word(event_word(OP_DEADLINE, cur_gen, cur_opid, '0));
        send_word(event_word(OP_DEADLINE, cur_gen, cur_opid, '0));
        send_word(event_word(OP_STOP, cur_gen, cur_opid, '0));

        for (int s = 0; s < 5; s++) begin
            write_invalid_handle(handle_settings[s]);
            for (int n = 0; n < EVENTS_PER_SETTING; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;

                cur    = lifecycle_now;
                active = (cur.next_phase != CODE_IDLE) && (cur.next_phase != CODE_STOPPED) &&
                         (cur.next_phase != CODE_BACKOFF);
                w    = event_word(OP_STOP, cur.next_generation, cur.next_operation_id,
                                  16'($urandom));
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    // Mostly the next step of a well-formed connection attempt.
                    case (cur.next_phase)
                        CODE_IDLE, CODE_STOPPED: begin
                            w.op = OP_START;
                            w.event_operation_id = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
                        end
                        CODE_SCAN: w.op = ($urandom_range(0, 2) == 0) ? OP_SCAN_START : OP_ADVERT;
                        CODE_CAND: w.op = OP_CONN_ISSUED;
                        CODE_CONN: w.op = OP_CONNECTED;
                        CODE_DISC: w.op = OP_DISCOVERED;
                        CODE_SUBS: w.op = OP_SUBSCRIBED;
                        CODE_INIT: w.op = OP_INITIALIZED;
                        CODE_READY: begin
                            w.op = ($urandom_range(0, 7) == 0) ? OP_STOP
                                 : OP_DISCONNECT + 4'($urandom_range(0, 2));
                        end
                        CODE_BACKOFF: begin
                            w.op = OP_BACKOFF_EXP;
                            w.event_operation_id = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
                        end
                        default: w.op = OP_STOP;
                    endcase
                    if (active && cur.next_operation_id == '0) begin
                        w.op = OP_STOP;
                    end else if (active && $urandom_range(0, 15) == 0) begin
                        w.op = OP_DISCONNECT + 4'($urandom_range(0, 2));
                    end
                end else begin
                    w.op = 4'($urandom);
                    if ($urandom_range(0, 1) == 0) w.event_generation = $urandom;
                    case ($urandom_range(0, 2))
                        0: w.event_operation_id = $urandom;
                        1: w.event_operation_id = '0;
                        default: ;
                    endcase
                end
                send_word(w);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Drove %0d lifecycle events across %0d invalid-handle settings.",
                 events_sent, handle_writes);
        $display("Checked %0d result words, %0d of them for accepted events.",
                 results_checked, events_accepted);
        if (mismatches == 0) begin
            $display("** link_lifecycle_fsm: PASSED **");
        end else begin
            $display("** link_lifecycle_fsm: FAILED **");
        end
        $finish;
    end

endmodule
